[rtl/core/rtx_pkg.sv]
// Shared types and constants for the signed integer to radix text block.
// No dependencies.
package rtx_pkg;

   localparam int VALUE_W  = 32;
   localparam int SYM_W    = 8;
   localparam int SYM_NUM  = 16;
   localparam int DIGIT_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYM_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_HIGH  = 2'd2;

   localparam logic [COUNT_W-1:0] SYM_COUNT_RST = 5'd10;
   localparam logic [CSR_W-1:0]   SYM_LOW_RST   = 64'h3837363534333231;
   localparam logic [CSR_W-1:0]   SYM_HIGH_RST  = 64'h0000000000003938;

   localparam logic [SYM_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [SYM_W-1:0] CHAR_DEL   = 8'd127;
   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'd43;

   typedef struct packed {
      logic done;
      logic quot_zero;
   } div_status_type;

endpackage

[rtl/core/rtx_div.sv]
// Bit-serial restoring divider: 32-bit dividend by a radix of at most 16.
// One quotient bit per cycle. Depends on rtx_pkg.
module rtx_div
   import rtx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [VALUE_W-1:0]   dividend,
   input  logic [COUNT_W-1:0]   radix,
   output div_status_type       status,
   output logic [VALUE_W-1:0]   quotient,
   output logic [DIGIT_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(VALUE_W);

   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIGIT_W:0]   trial;
   logic               ge;

   assign trial = {rem_ff, mag_ff[VALUE_W-1]};
   assign ge    = (trial >= radix);

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[VALUE_W-2:0], ge};
         rem_in = ge ? DIGIT_W'(trial - radix) : DIGIT_W'(trial);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done      = done_ff;
   assign status.quot_zero = (mag_ff == '0);
   assign quotient         = mag_ff;
   assign remainder        = rem_ff;

endmodule

[rtl/core/signed_integer_to_radix_text_top.sv]
// Top level: signed 32-bit value to text in a configurable radix.
// Depends on rtx_pkg and rtx_div.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_value
//   rsp      out  rsp_valid/rsp_stall   rsp_char_code, rsp_last_of_run
//   csr      in   csr_write_en          csr_index, csr_wdata
//
// One item at a time. An item is accepted, its symbol set is checked symbol by
// symbol, each digit comes from the bit-serial divider, then characters go out
// one per cycle while rsp is not stalled; a bad symbol set gives no text.
// Synchronous reset clears control and restores the register defaults.
// req_stall is high while an item is in work; a stall on rsp holds the result.
module signed_integer_to_radix_text_top
   import rtx_pkg::*;
#(
   parameter int MAX_SYMBOLS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SYM_W-1:0]          rsp_char_code,
   output logic                      rsp_last_of_run,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam int ND_W  = $clog2(VALUE_W) + 1;
   localparam int IDX_W = $clog2(SYM_NUM);
   localparam int STK_W = VALUE_W * DIGIT_W;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CSR_W-1:0]   low_ff, low_in;
   logic [CSR_W-1:0]   high_ff, high_in;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [ND_W-1:0]    nd_ff, nd_in;
   logic [STK_W-1:0]   stk_ff, stk_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]   char_ff, char_in;
   logic               last_ff, last_in;

   logic [2*CSR_W-1:0] syms;
   logic [SYM_W-1:0]   sym;
   logic               bad_char;
   logic               dup;
   logic               accept;
   logic               count_ok;
   logic               slot_free;
   logic               div_start;
   logic [VALUE_W-1:0] div_dividend;
   div_status_type     div_status;
   logic [VALUE_W-1:0] div_quot;
   logic [DIGIT_W-1:0] div_rem;

   rtx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (count_ff),
      .status    (div_status),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign syms      = {high_ff, low_ff};
   assign sym       = syms[{idx_ff, 3'b000} +: SYM_W];
   assign bad_char  = (sym <= CHAR_SPACE) || (sym >= CHAR_DEL) ||
                      (sym == CHAR_MINUS) || (sym == CHAR_PLUS);
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign count_ok  = (count_ff >= 5'd2) && (count_ff <= COUNT_W'(MAX_SYMBOLS));
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < SYM_NUM; j++) begin
         if ((IDX_W'(j) > idx_ff) && (COUNT_W'(j) < count_ff) &&
             (syms[j*SYM_W +: SYM_W] == sym)) begin
            dup = 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SYM_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            CSR_SYM_LOW:   low_in   = csr_wdata;
            CSR_SYM_HIGH:  high_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      nd_in        = nd_ff;
      stk_in       = stk_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      div_dividend = mag_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = req_value[VALUE_W-1];
               mag_in = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                             : VALUE_W'(req_value);
               idx_in = '0;
               nd_in  = '0;
               if (count_ok) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            idx_in = idx_ff + 1'b1;
            if (bad_char || dup) begin
               state_in = ST_IDLE;
            end else if (idx_ff == IDX_W'(count_ff - 5'd1)) begin
               state_in  = ST_DIV;
               div_start = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               stk_in = {stk_ff[STK_W-DIGIT_W-1:0], div_rem};
               nd_in  = nd_ff + 1'b1;
               if (div_status.quot_zero || (nd_ff == ND_W'(VALUE_W - 1))) begin
                  state_in = ST_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quot;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  char_in = CHAR_MINUS;
                  last_in = 1'b0;
                  neg_in  = 1'b0;
               end else begin
                  char_in = syms[{stk_ff[DIGIT_W-1:0], 3'b000} +: SYM_W];
                  last_in = (nd_ff == ND_W'(1));
                  stk_in  = {DIGIT_W'(0), stk_ff[STK_W-1:DIGIT_W]};
                  nd_in   = nd_ff - 1'b1;
                  if (nd_ff == ND_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      mag_ff  <= mag_in;
      stk_ff  <= stk_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         count_ff     <= SYM_COUNT_RST;
         low_ff       <= SYM_LOW_RST;
         high_ff      <= SYM_HIGH_RST;
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         nd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         nd_ff        <= nd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_code   = char_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[dv/signed_integer_to_radix_text_top_test.sv]
`timescale 1ns / 1ps
// Testbench for signed_integer_to_radix_text_top: drives values and symbol sets and
// checks every character of the text against a predictor built in here.
// Depends on rtx_pkg and the block's RTL.
module signed_integer_to_radix_text_top_test;
   import rtx_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int                   SETTLE_CYCLES = 1200;
   localparam int                   HOLD_CYCLES   = 1500;
   localparam longint               CYCLE_LIMIT   = 3000000;
   localparam logic [CSR_W-1:0]     DIGITS_LOW    = 64'h3736353433323130;
   localparam logic [CSR_W-1:0]     HEX_HIGH      = 64'h4645444342413938;

   typedef struct packed {
      logic [SYM_W-1:0] code;
      logic             last;
   } text_char_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SYM_W-1:0]          rsp_char_code;
   logic                      rsp_last_of_run;
   logic                      csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;

   logic [COUNT_W-1:0] sym_count = SYM_COUNT_RST;
   logic [CSR_W-1:0]   sym_low   = SYM_LOW_RST;
   logic [CSR_W-1:0]   sym_high  = SYM_HIGH_RST;

   logic signed [VALUE_W-1:0] value_queue[$];
   text_char_type             due_chars[$];
   int                        items_pushed = 0;
   int                        items_accepted = 0;
   int                        error_count = 0;
   longint                    cycle_count = 0;
   logic                      req_taken = 1'b0;
   bit                        idle_on = 1'b1;
   bit                        hold_arm = 1'b0;
   bit                        hold_used = 1'b0;
   int                        send_gap = 0;
   int                        rcv_gap = 0;
   int                        long_hold = 0;

   signed_integer_to_radix_text_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_code   (rsp_char_code),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ---------------- predictor ----------------
   function automatic logic [SYM_W-1:0] sym_byte(int unsigned k);
      logic [2*CSR_W-1:0] all_syms;
      all_syms = {sym_high, sym_low};
      return all_syms[k*SYM_W +: SYM_W];
   endfunction

   function automatic bit symbol_set_ok();
      logic [SYM_W-1:0] s;
      if (sym_count < 2 || sym_count > SYM_NUM) return 1'b0;
      for (int i = 0; i < sym_count; i++) begin
         s = sym_byte(i);
         if (s <= CHAR_SPACE || s >= CHAR_DEL || s == CHAR_MINUS || s == CHAR_PLUS)
            return 1'b0;
         for (int j = i + 1; j < sym_count; j++)
            if (sym_byte(j) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_text(logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      logic [DIGIT_W-1:0] digs[VALUE_W];
      int                 nd;
      if (!symbol_set_ok()) return;
      radix = VALUE_W'(sym_count);
      mag = raw[VALUE_W-1] ? -raw : raw;
      nd = 0;
      do begin
         digs[nd] = DIGIT_W'(mag % radix);
         mag = mag / radix;
         nd++;
      end while (mag != 0 && nd < VALUE_W);
      if (raw[VALUE_W-1]) due_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
      for (int k = nd - 1; k >= 0; k--)
         due_chars.push_back('{code: sym_byte(digs[k]), last: (k == 0)});
   endfunction

   // ---------------- request side ----------------
   always @(negedge clock) begin : drive_req
      logic                      nxt_valid;
      logic signed [VALUE_W-1:0] nxt_value;
      nxt_valid = req_valid;
      nxt_value = req_value;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         nxt_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (value_queue.size() > 0) begin
            nxt_value = value_queue.pop_front();
            nxt_valid = 1'b1;
            if (idle_on && $urandom_range(99) < 25) send_gap = $urandom_range(18, 1);
         end
      end
      req_valid <= nxt_valid;
      req_value <= nxt_value;
   end

   always @(posedge clock) begin : accept_req
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_text(req_value);
         items_accepted++;
      end
   end

   // ---------------- result side ----------------
   always @(negedge clock) begin : drive_rsp
      logic nxt;
      nxt = 1'b0;
      if (reset) begin
         nxt = 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         nxt = 1'b1;
      end else if (hold_arm && !hold_used) begin
         hold_used = 1'b1;
         long_hold = HOLD_CYCLES - 1;
         nxt = 1'b1;
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         nxt = 1'b1;
      end else if (idle_on && $urandom_range(99) < 8) begin
         rcv_gap = $urandom_range(18, 1);
      end
      rsp_stall <= nxt;
   end

   task automatic flag_error(string what);
      if (error_count < 10) $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_chars.size() == 0) begin
            flag_error($sformatf("unexpected char %0d last %0d", rsp_char_code,
                                 rsp_last_of_run));
         end else begin
            want = due_chars.pop_front();
            if (rsp_char_code !== want.code || rsp_last_of_run !== want.last)
               flag_error($sformatf("expected char %0d last %0d, got char %0d last %0d",
                                    want.code, want.last, rsp_char_code, rsp_last_of_run));
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic offer(logic signed [VALUE_W-1:0] v);
      value_queue.push_back(v);
      items_pushed++;
   endtask

   task automatic wait_answered();
      wait (items_accepted == items_pushed && due_chars.size() == 0);
   endtask

   task automatic wait_idle();
      wait_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_SYM_COUNT: sym_count = data[COUNT_W-1:0];
         CSR_SYM_LOW:   sym_low   = data;
         CSR_SYM_HIGH:  sym_high  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_symbols(int unsigned cnt, logic [2*CSR_W-1:0] syms);
      logic [CSR_W-1:0] w;
      w = {$urandom, $urandom};
      w[COUNT_W-1:0] = COUNT_W'(cnt);
      csr_write(CSR_SYM_COUNT, w);
      csr_write(CSR_SYM_LOW, syms[CSR_W-1:0]);
      csr_write(CSR_SYM_HIGH, syms[2*CSR_W-1:CSR_W]);
   endtask

   function automatic logic [2*CSR_W-1:0] make_symbols(int unsigned radix);
      logic [2*CSR_W-1:0] syms;
      bit [255:0]         used;
      logic [SYM_W-1:0]   b;
      syms = {$urandom, $urandom, $urandom, $urandom};
      used = '0;
      for (int i = 0; i < radix; i++) begin
         do b = SYM_W'($urandom_range(126, 33));
         while (b == CHAR_PLUS || b == CHAR_MINUS || used[b]);
         used[b] = 1'b1;
         syms[i*SYM_W +: SYM_W] = b;
      end
      return syms;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value(int unsigned radix);
      logic [VALUE_W-1:0] mag;
      int unsigned        sel;
      sel = $urandom_range(9);
      if (sel < 4) begin
         mag = $urandom;
      end else if (sel < 6) begin
         mag = $urandom_range(radix * radix);
      end else if (sel < 8) begin
         mag = 1;
         repeat ($urandom_range(31, 1))
            if (mag <= 32'hFFFF_FFFF / radix) mag = mag * radix;
         mag = mag - $urandom_range(1);
      end else begin
         case ($urandom_range(4))
            0: mag = 32'h7FFF_FFFF;
            1: mag = 32'h8000_0000;
            2: mag = 32'h0;
            3: mag = 32'hFFFF_FFFF;
            default: mag = 32'h1;
         endcase
      end
      return $urandom_range(1) ? -mag : mag;
   endfunction

   initial begin : stimulus
      logic [2*CSR_W-1:0] syms;
      logic [SYM_W-1:0]   bad;
      int unsigned        cnt;
      int unsigned        pos;
      int unsigned        radix;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset symbol set repeats a symbol: nothing comes out
      offer(5);
      offer(-7);
      wait_idle();

      load_symbols(10, {$urandom, 16'($urandom), 16'h3938, DIGITS_LOW});
      csr_write(CSR_UNMAPPED, {$urandom, $urandom});
      offer(0);
      offer(7);
      offer(-1);
      offer(32'sh7FFF_FFFF);
      offer(32'sh8000_0000);
      offer(10);
      offer(-100);
      wait_idle();

      // radix 2 with the lowest and highest printable symbols
      load_symbols(2, {$urandom, $urandom, $urandom, 16'($urandom), 8'd126, 8'd33});
      offer(0);
      offer(32'sh8000_0000);
      offer(32'sh7FFF_FFFF);
      offer(-1);
      offer(5);
      wait_idle();

      load_symbols(16, {HEX_HIGH, DIGITS_LOW});
      offer(32'sh8000_0000);
      offer(32'shDEAD_BEEF);
      offer(255);
      offer(0);

      // broken symbol sets
      for (int i = 0; i < 10; i++) begin
         wait_idle();
         syms = {HEX_HIGH, DIGITS_LOW};
         cnt = 16;
         pos = $urandom_range(15);
         bad = syms[pos*SYM_W +: SYM_W];
         case (i)
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 17;
            3: cnt = 31;
            4: bad = CHAR_SPACE;
            5: bad = CHAR_DEL;
            6: bad = 8'hC8;
            7: bad = CHAR_MINUS;
            8: bad = CHAR_PLUS;
            default: bad = syms[((pos + 1 + $urandom_range(14)) % 16)*SYM_W +: SYM_W];
         endcase
         syms[pos*SYM_W +: SYM_W] = bad;
         load_symbols(cnt, syms);
         offer(pick_value(10));
      end

      for (int ph = 0; ph < 13; ph++) begin
         wait_idle();
         idle_on = (ph != 12) && ($urandom_range(4) != 0);
         if (ph % 6 == 5) begin
            load_symbols($urandom_range(31), {$urandom, $urandom, $urandom, $urandom});
            repeat (8) offer(pick_value(10));
         end else begin
            radix = (ph == 0) ? 2 : (ph == 1) ? 16 : $urandom_range(16, 2);
            load_symbols(radix, make_symbols(radix));
            if (ph == 2) hold_arm = 1'b1;
            repeat (19) offer(pick_value(radix));
            if (ph == 3) wait_answered();
            repeat (19) offer(pick_value(radix));
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/rtx_pkg.sv
rtl/core/rtx_div.sv
rtl/core/signed_integer_to_radix_text_top.sv
dv/signed_integer_to_radix_text_top_test.sv
